@@ rtl/clock_frame_replacement_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the clock frame replacement block
// Each macro expects signals named clock and reset in the using module.
// ---------------------------------------------------------------------------
`ifndef CLOCK_FRAME_REPLACEMENT_TOP_ASSERT_SVH
`define CLOCK_FRAME_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication
`define CFR_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cfr_pkg.sv @@
// ---------------------------------------------------------------------------
// cfr_pkg
// Shared constants, codes and control types of the frame replacement block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

   localparam int DEF_NUM_FRAMES = 64;
   localparam int DEF_PAGE_BITS  = 20;

   localparam int KIND_W   = 3;
   localparam int PAGE_W   = 20;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TOUCH   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PIN     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNPIN   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd2;

   typedef struct packed {
      logic valid;
      logic referenced;
      logic pinned;
   } flags_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;           // reset sweep, one entry per cycle
      logic capture;         // latch request beat
      logic scan_init_free;
      logic scan_init_hand;
      logic scan_free;       // lowest free slot search, places on hit
      logic scan_hand;       // clock sweep, evicts on hit
      logic mark_oob;
      logic slot_read;
      logic slot_apply;
      logic load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              clear_last;
      logic              full;
      logic              slot_oob;
      logic              found;
      logic              fail;
      logic              out_free;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/cfr_req_if.sv @@
// ---------------------------------------------------------------------------
// cfr_req_if
// Request channel: valid/ready handshake with the request payload.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [cfr_pkg::KIND_W-1:0]   kind;
   logic [cfr_pkg::PAGE_W-1:0]   page_number;
   logic [cfr_pkg::SLOT_W-1:0]   slot;

   modport source (output valid, output kind, output page_number, output slot,
                   input ready);
   modport sink   (input valid, input kind, input page_number, input slot,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/cfr_rsp_if.sv @@
// ---------------------------------------------------------------------------
// cfr_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cfr_pkg::STATUS_W-1:0]  status;
   logic [cfr_pkg::SLOT_W-1:0]    granted_slot;
   logic                          evicted;
   logic [cfr_pkg::PAGE_W-1:0]    evicted_page;

   modport source (output valid, output status, output granted_slot, output evicted,
                   output evicted_page, input ready);
   modport sink   (input valid, input status, input granted_slot, input evicted,
                   input evicted_page, output ready);
endinterface

`default_nettype wire

@@ rtl/cfr_ram.sv @@
// ---------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/cfr_ctrl.sv @@
// ---------------------------------------------------------------------------
// cfr_ctrl
// Sequencer: reset sweep, request decode, slot scans and response hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire cfr_pkg::stat_type  st,
   output cfr_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_FREE,
      ST_SCAN_HAND,
      ST_SLOT_APPLY,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (st.kind)
               cfr_pkg::KIND_ALLOC: begin
                  if (st.full) begin
                     cmd.scan_init_hand = 1'b1;
                     state_in           = ST_SCAN_HAND;
                  end else begin
                     cmd.scan_init_free = 1'b1;
                     state_in           = ST_SCAN_FREE;
                  end
               end
               cfr_pkg::KIND_TOUCH, cfr_pkg::KIND_PIN,
               cfr_pkg::KIND_UNPIN, cfr_pkg::KIND_RELEASE: begin
                  if (st.slot_oob) begin
                     cmd.mark_oob = 1'b1;
                     state_in     = ST_RESPOND;
                  end else begin
                     cmd.slot_read = 1'b1;
                     state_in      = ST_SLOT_APPLY;
                  end
               end
               default: begin
                  state_in = ST_RESPOND;
               end
            endcase
         end
         ST_SCAN_FREE: begin
            cmd.scan_free = 1'b1;
            if (st.found) begin
               state_in = ST_RESPOND;
            end
         end
         ST_SCAN_HAND: begin
            cmd.scan_hand = 1'b1;
            if (st.found || st.fail) begin
               state_in = ST_RESPOND;
            end
         end
         ST_SLOT_APPLY: begin
            cmd.slot_apply = 1'b1;
            state_in       = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (st.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE) && !cmd.capture;
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

@@ rtl/cfr_dp.sv @@
// ---------------------------------------------------------------------------
// cfr_dp
// Frame table datapath: flag and page RAMs, scan pointer, clock hand,
// resident count and the response register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "clock_frame_replacement_top_assert.svh"

module cfr_dp #(
   parameter int NUM_FRAMES = cfr_pkg::DEF_NUM_FRAMES,
   parameter int PAGE_BITS  = cfr_pkg::DEF_PAGE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cfr_pkg::cmd_type                cmd,
   output cfr_pkg::stat_type                    st,
   input  wire logic [cfr_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [cfr_pkg::PAGE_W-1:0]      req_page_number,
   input  wire logic [cfr_pkg::SLOT_W-1:0]      req_slot,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic      [cfr_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [cfr_pkg::SLOT_W-1:0]      rsp_granted_slot,
   output logic                                 rsp_evicted,
   output logic      [cfr_pkg::PAGE_W-1:0]      rsp_evicted_page
);

   localparam int AW = $clog2(NUM_FRAMES);
   localparam int CW = $clog2(NUM_FRAMES + 1);
   localparam int SW = $clog2(2 * NUM_FRAMES);
   localparam int PW = (PAGE_BITS < cfr_pkg::PAGE_W) ? PAGE_BITS : cfr_pkg::PAGE_W;
   localparam int FW = $bits(cfr_pkg::flags_type);

   localparam logic [AW-1:0] LAST_IDX  = AW'(NUM_FRAMES - 1);
   localparam logic [SW-1:0] LAST_STEP = SW'(2 * NUM_FRAMES - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(NUM_FRAMES);

   // request latch
   logic [cfr_pkg::KIND_W-1:0]   kind_ff;
   logic [PW-1:0]                page_ff;
   logic [cfr_pkg::SLOT_W-1:0]   slot_ff;

   // scan and table state
   logic [AW-1:0] idx_ff, eval_ff, hand_ff;
   logic          pend_ff;
   logic [SW-1:0] steps_ff;
   logic [CW-1:0] count_ff;

   // result under construction
   logic [cfr_pkg::STATUS_W-1:0] res_status_ff;
   logic [cfr_pkg::SLOT_W-1:0]   res_granted_ff;
   logic                         res_evicted_ff;
   logic [cfr_pkg::PAGE_W-1:0]   res_evpage_ff;

   logic                         rsp_valid_ff;
   logic [cfr_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [cfr_pkg::SLOT_W-1:0]   rsp_granted_ff;
   logic                         rsp_evicted_ff;
   logic [cfr_pkg::PAGE_W-1:0]   rsp_evpage_ff;

   logic [AW-1:0]       slot_addr, idx_inc, eval_inc, rd_addr, wr_addr;
   logic [FW-1:0]       flags_rd_raw;
   cfr_pkg::flags_type  flags_rd, wr_flags;
   logic [PW-1:0]       page_rd;
   logic                flags_wr, page_wr;
   logic                free_hit, victim, sweep_fail;

   assign slot_addr = AW'(slot_ff);
   assign idx_inc   = (idx_ff == LAST_IDX) ? '0 : idx_ff + AW'(1);
   assign eval_inc  = (eval_ff == LAST_IDX) ? '0 : eval_ff + AW'(1);
   assign rd_addr   = cmd.slot_read ? slot_addr : idx_ff;
   assign flags_rd  = cfr_pkg::flags_type'(flags_rd_raw);

   assign free_hit   = cmd.scan_free && pend_ff && !flags_rd.valid;
   assign victim     = cmd.scan_hand && pend_ff && !flags_rd.pinned && !flags_rd.referenced;
   assign sweep_fail = cmd.scan_hand && pend_ff && !victim && (steps_ff == LAST_STEP);

   always_comb begin
      flags_wr = 1'b0;
      page_wr  = 1'b0;
      wr_addr  = eval_ff;
      wr_flags = '0;
      if (cmd.clear) begin
         flags_wr = 1'b1;
         wr_addr  = idx_ff;
      end else if (free_hit || victim) begin
         flags_wr            = 1'b1;
         page_wr             = 1'b1;
         wr_flags.valid      = 1'b1;
         wr_flags.referenced = 1'b1;
      end else if (cmd.scan_hand && pend_ff && !flags_rd.pinned) begin
         // second chance: drop the accessed mark and move on
         flags_wr       = 1'b1;
         wr_flags.valid = flags_rd.valid;
      end else if (cmd.slot_apply && flags_rd.valid) begin
         flags_wr = 1'b1;
         wr_addr  = slot_addr;
         wr_flags = flags_rd;
         case (kind_ff)
            cfr_pkg::KIND_TOUCH:   wr_flags.referenced = 1'b1;
            cfr_pkg::KIND_PIN:     wr_flags.pinned     = 1'b1;
            cfr_pkg::KIND_UNPIN:   wr_flags.pinned     = 1'b0;
            cfr_pkg::KIND_RELEASE: wr_flags            = '0;
            default:               wr_flags            = flags_rd;
         endcase
      end
   end

   cfr_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_flags_ram (
      .clock   (clock),
      .wr_en   (flags_wr),
      .wr_addr (wr_addr),
      .wr_data (FW'(wr_flags)),
      .rd_addr (rd_addr),
      .rd_data (flags_rd_raw)
   );

   cfr_ram #(.WIDTH(PW), .DEPTH(NUM_FRAMES)) u_page_ram (
      .clock   (clock),
      .wr_en   (page_wr),
      .wr_addr (eval_ff),
      .wr_data (page_ff),
      .rd_addr (rd_addr),
      .rd_data (page_rd)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff        <= req_kind;
         page_ff        <= PW'(req_page_number);
         slot_ff        <= req_slot;
         res_status_ff  <= cfr_pkg::STATUS_DONE;
         res_granted_ff <= '0;
         res_evicted_ff <= 1'b0;
         res_evpage_ff  <= '0;
      end
      if (cmd.mark_oob) begin
         res_status_ff <= cfr_pkg::STATUS_BAD_SLOT;
      end
      if (cmd.slot_apply && !flags_rd.valid) begin
         res_status_ff <= cfr_pkg::STATUS_BAD_SLOT;
      end
      if (free_hit || victim) begin
         res_granted_ff <= cfr_pkg::SLOT_W'(eval_ff);
      end
      if (victim) begin
         res_evicted_ff <= 1'b1;
         res_evpage_ff  <= cfr_pkg::PAGE_W'(page_rd);
      end
      if (sweep_fail) begin
         res_status_ff <= cfr_pkg::STATUS_NO_FRAME;
      end
      if (cmd.load_out) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_evicted_ff <= res_evicted_ff;
         rsp_evpage_ff  <= res_evpage_ff;
      end
      if (cmd.scan_init_free || cmd.scan_init_hand) begin
         eval_ff <= '0;
      end else if (cmd.scan_free || cmd.scan_hand) begin
         eval_ff <= idx_ff;
      end
      if (cmd.scan_init_hand) begin
         steps_ff <= '0;
      end else if (cmd.scan_hand && pend_ff) begin
         steps_ff <= steps_ff + SW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         hand_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan_init_free) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.scan_init_hand) begin
            idx_ff  <= hand_ff;
            pend_ff <= 1'b0;
         end else if (cmd.clear || cmd.scan_free || cmd.scan_hand) begin
            idx_ff  <= idx_inc;
            pend_ff <= cmd.scan_free || cmd.scan_hand;
         end
         if (free_hit) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.slot_apply && flags_rd.valid && kind_ff == cfr_pkg::KIND_RELEASE) begin
            count_ff <= count_ff - CW'(1);
         end
         if (victim) begin
            hand_ff <= eval_inc;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      st            = '0;
      st.kind       = kind_ff;
      st.clear_last = (idx_ff == LAST_IDX);
      st.full       = (count_ff == FULL_CNT);
      st.slot_oob   = (int'(slot_ff) >= NUM_FRAMES);
      st.found      = free_hit || victim;
      st.fail       = sweep_fail;
      st.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evpage_ff;

   `CFR_ASSERT_IMP(a_load_needs_room, cmd.load_out, !rsp_valid_ff || rsp_ready, "response overwritten")
   `CFR_ASSERT_NXT(a_hand_holds, cmd.scan_hand && !victim, $stable(hand_ff), "hand moved without eviction")
   `CFR_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= FULL_CNT, "resident count above frame count")
   `CFR_ASSERT_NXT(a_release_count, cmd.slot_apply && flags_rd.valid && kind_ff == cfr_pkg::KIND_RELEASE, count_ff == $past(count_ff) - CW'(1), "release did not drop count")
   `CFR_ASSERT_IMP(a_free_scan_not_full, cmd.scan_free, count_ff != FULL_CNT, "free scan on a full table")

endmodule

`default_nettype wire

@@ rtl/clock_frame_replacement_top.sv @@
// ---------------------------------------------------------------------------
// clock_frame_replacement_top
// Clock (second-chance) physical frame table with allocate, touch, pin,
// unpin and release requests.
//   req_ch carries one request beat (kind, page_number, slot); rsp_ch returns
//   exactly one result beat (status, granted_slot, evicted, evicted_page) per
//   request, in order. One request is in flight at a time; req_ch.ready rises
//   again once the result has been moved to the output register.
//   Allocate with a free frame scans from slot 0 to the lowest free slot;
//   allocate on a full table sweeps the clock hand, visiting at most
//   2*NUM_FRAMES frames when everything is pinned.
//   The flag RAM has one read port, so each scan visits one frame per cycle.
//   After reset the flag RAM is swept clear with req_ch.ready low. Page
//   storage is not cleared.
//   If rsp_ch stalls, the finished result waits in its register while the
//   next request is decoded and processed; that request's result waits in
//   the block until the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clock_frame_replacement_top #(
   parameter int NUM_FRAMES = cfr_pkg::DEF_NUM_FRAMES,
   parameter int PAGE_BITS  = cfr_pkg::DEF_PAGE_BITS
) (
   input wire logic    clock,
   input wire logic    reset,
   cfr_req_if.sink     req_ch,
   cfr_rsp_if.source   rsp_ch
);

   cfr_pkg::cmd_type  cmd;
   cfr_pkg::stat_type st;

   cfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   cfr_dp #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_kind         (req_ch.kind),
      .req_page_number  (req_ch.page_number),
      .req_slot         (req_ch.slot),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_status       (rsp_ch.status),
      .rsp_granted_slot (rsp_ch.granted_slot),
      .rsp_evicted      (rsp_ch.evicted),
      .rsp_evicted_page (rsp_ch.evicted_page)
   );

endmodule

`default_nettype wire
